@@ hw/rtl/ptw_pkg.sv @@
// shared types and constants for the two-level page walker
`default_nettype none

package ptw_pkg;

   localparam int unsigned ADDR_W      = 32;
   localparam int unsigned PAGE_BITS   = 12;
   localparam int unsigned INDEX_BITS  = 10;
   localparam int unsigned DIR_SHIFT   = 22;
   localparam int unsigned TBL_SHIFT   = 12;
   localparam int unsigned PRESENT_BIT = 0;

   localparam int unsigned REQ_DATA_W = 64;
   localparam int unsigned RSP_DATA_W = 72;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 32;

   // beat kinds on the request side
   localparam logic REQ_TRANSLATE = 1'b0;
   localparam logic REQ_READ_RSP  = 1'b1;

   // beat kinds on the response side
   localparam logic OUT_MEM_READ = 1'b0;
   localparam logic OUT_RESULT   = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_BASE      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAGING_ON     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DIRECT_MAP_ON = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_LIMIT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_POISON_CHK_ON = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_POISON_WORD   = 3'd5;

   localparam logic [ADDR_W-1:0] RST_DIR_BASE     = 32'h0000_0000;
   localparam logic [ADDR_W-1:0] RST_KERNEL_LIMIT = 32'h0100_0000;
   localparam logic [ADDR_W-1:0] RST_POISON_WORD  = 32'h0000_0000;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_DIR  = 2'd1,
      PH_TBL  = 2'd2
   } phase_type;

   typedef struct packed {
      logic [ADDR_W-1:0] dir_base;
      logic              paging_on;
      logic              direct_map_on;
      logic [ADDR_W-1:0] kernel_limit;
      logic              poison_check_on;
      logic [ADDR_W-1:0] poison_word;
   } cfg_type;

   typedef struct packed {
      logic              req_type;
      logic [ADDR_W-1:0] virt_addr;
      logic [ADDR_W-1:0] read_word;
   } item_type;

   typedef struct packed {
      logic              out_kind;
      logic [ADDR_W-1:0] mem_addr;
      logic [ADDR_W-1:0] xlat_addr;
      logic              ok;
   } result_type;

endpackage

`default_nettype wire

@@ hw/rtl/ptw_csr.sv @@
// configuration register file of the page walker
`default_nettype none

module ptw_csr (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                csr_wr_en,
   input  wire  [ptw_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire  [ptw_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output ptw_pkg::cfg_type                   cfg
);

   ptw_pkg::cfg_type cfg_ff;
   ptw_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            ptw_pkg::CSR_DIR_BASE:      cfg_in.dir_base        = csr_wdata;
            ptw_pkg::CSR_PAGING_ON:     cfg_in.paging_on       = csr_wdata[0];
            ptw_pkg::CSR_DIRECT_MAP_ON: cfg_in.direct_map_on   = csr_wdata[0];
            ptw_pkg::CSR_KERNEL_LIMIT:  cfg_in.kernel_limit    = csr_wdata;
            ptw_pkg::CSR_POISON_CHK_ON: cfg_in.poison_check_on = csr_wdata[0];
            ptw_pkg::CSR_POISON_WORD:   cfg_in.poison_word     = csr_wdata;
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dir_base        <= ptw_pkg::RST_DIR_BASE;
         cfg_ff.paging_on       <= 1'b0;
         cfg_ff.direct_map_on   <= 1'b1;
         cfg_ff.kernel_limit    <= ptw_pkg::RST_KERNEL_LIMIT;
         cfg_ff.poison_check_on <= 1'b0;
         cfg_ff.poison_word     <= ptw_pkg::RST_POISON_WORD;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

@@ hw/rtl/ptw_walk.sv @@
// walk state machine and address arithmetic for one item
`default_nettype none

module ptw_walk (
   input  wire                      clock,
   input  wire                      reset,
   input  wire ptw_pkg::cfg_type    cfg,
   input  wire                      fire,
   input  wire ptw_pkg::item_type   item,
   output logic                     res_valid,
   output ptw_pkg::result_type      res,
   output ptw_pkg::phase_type       phase
);

   ptw_pkg::phase_type              phase_ff;
   ptw_pkg::phase_type              phase_in;
   logic [ptw_pkg::ADDR_W-1:0]      held_addr_ff;
   logic [ptw_pkg::ADDR_W-1:0]      held_addr_in;

   logic                            busy;
   logic                            entry_bad;
   logic [ptw_pkg::ADDR_W-1:0]      dir_addr;
   logic [ptw_pkg::ADDR_W-1:0]      tbl_addr;
   logic [ptw_pkg::ADDR_W-1:0]      frame_addr;

   assign busy = (phase_ff == ptw_pkg::PH_DIR) || (phase_ff == ptw_pkg::PH_TBL);

   assign entry_bad = !item.read_word[ptw_pkg::PRESENT_BIT] ||
                      (cfg.poison_check_on && (item.read_word == cfg.poison_word));

   // directory entry: base plus four times the top ten bits, wraps
   assign dir_addr = cfg.dir_base +
                     {20'd0, item.virt_addr[ptw_pkg::ADDR_W-1:ptw_pkg::DIR_SHIFT], 2'b00};

   // frame bits and the index never overlap, so the sum is a concatenation
   assign tbl_addr = {item.read_word[ptw_pkg::ADDR_W-1:ptw_pkg::PAGE_BITS],
                      held_addr_ff[ptw_pkg::DIR_SHIFT-1:ptw_pkg::TBL_SHIFT], 2'b00};

   assign frame_addr = {item.read_word[ptw_pkg::ADDR_W-1:ptw_pkg::PAGE_BITS],
                        held_addr_ff[ptw_pkg::PAGE_BITS-1:0]};

   always_comb begin
      phase_in      = phase_ff;
      held_addr_in  = held_addr_ff;
      res_valid     = 1'b0;
      res.out_kind  = ptw_pkg::OUT_RESULT;
      res.mem_addr  = '0;
      res.xlat_addr = '0;
      res.ok        = 1'b0;
      if (fire) begin
         if (item.req_type == ptw_pkg::REQ_TRANSLATE) begin
            if (!busy) begin
               res_valid = 1'b1;
               if (cfg.direct_map_on && (item.virt_addr < cfg.kernel_limit)) begin
                  res.xlat_addr = item.virt_addr;
                  res.ok        = 1'b1;
               end else if (cfg.paging_on) begin
                  res.out_kind = ptw_pkg::OUT_MEM_READ;
                  res.mem_addr = dir_addr;
                  held_addr_in = item.virt_addr;
                  phase_in     = ptw_pkg::PH_DIR;
               end
            end
         end else if (busy) begin
            res_valid = 1'b1;
            if (entry_bad) begin
               phase_in = ptw_pkg::PH_IDLE;
            end else begin
               case (phase_ff)
                  ptw_pkg::PH_DIR: begin
                     res.out_kind = ptw_pkg::OUT_MEM_READ;
                     res.mem_addr = tbl_addr;
                     phase_in     = ptw_pkg::PH_TBL;
                  end
                  default: begin
                     res.xlat_addr = frame_addr;
                     res.ok        = 1'b1;
                     phase_in      = ptw_pkg::PH_IDLE;
                  end
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= ptw_pkg::PH_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_addr_ff <= '0;
      end else begin
         held_addr_ff <= held_addr_in;
      end
   end

   assign phase = phase_ff;

endmodule

`default_nettype wire

@@ hw/rtl/ptw_out_reg.sv @@
// result register in front of the response channel
`default_nettype none

module ptw_out_reg (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      load,
   input  wire ptw_pkg::result_type res,
   input  wire                      rsp_tready,
   output logic                     rsp_tvalid,
   output ptw_pkg::result_type      held,
   output logic                     free
);

   logic                  valid_ff;
   logic                  valid_in;
   ptw_pkg::result_type   res_ff;

   assign free     = !valid_ff || rsp_tready;
   assign valid_in = load ? 1'b1 : (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= res;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign held       = res_ff;

endmodule

`default_nettype wire

@@ hw/rtl/two_level_page_walker_core.sv @@
// top level of the two-level page table walker
//
//  channel  direction  tdata (low bit up)                        tuser
//  req      in         virt_addr[31:0], read_word[63:32]          req_type
//  rsp      out        mem_addr[31:0], xlat_addr[63:32],          out_kind
//                      ok[64], zero pad [71:65]
//  csr      in         write enable, 3-bit index, 32-bit data     -
//
// one beat per cycle sustained while the rsp side does not stall; a beat
// is held in the input register and leaves the walk logic into the result
// register, which presents it as the response beat
// the walk phase and the held address are the only state carried between beats
// reset is synchronous; it clears the walk phase, both valid flags and the
// registers to their defaults, with no clearing pass
// a stalled rsp side backs up through the input register into req_tready;
// beats that cause no response (translate while busy, read data while idle)
// still pass through and are dropped
`default_nettype none

module two_level_page_walker_core (
   input  wire                               clock,
   input  wire                               reset,
   // request side
   input  wire                               req_tvalid,
   output logic                              req_tready,
   input  wire  [ptw_pkg::REQ_DATA_W-1:0]    req_tdata,   // virt_addr, read_word
   input  wire                               req_tuser,   // req_type
   // response side
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   output logic [ptw_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // mem_addr, xlat_addr, ok
   output logic                              rsp_tuser,   // out_kind
   // configuration
   input  wire                               csr_wr_en,
   input  wire  [ptw_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire  [ptw_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   ptw_pkg::cfg_type      cfg;
   ptw_pkg::item_type     item_ff;
   logic                  in_valid_ff;
   logic                  in_valid_in;
   logic                  advance;
   logic                  walk_fire;
   logic                  res_valid;
   ptw_pkg::result_type   res;
   ptw_pkg::result_type   out_res;
   ptw_pkg::phase_type    phase;
   logic                  out_free;
   logic                  req_fire;

   ptw_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // input register: moves on whenever the result register can take a beat
   assign advance     = out_free;
   assign walk_fire   = in_valid_ff && advance;
   assign req_tready  = !in_valid_ff || advance;
   assign req_fire    = req_tvalid && req_tready;
   assign in_valid_in = req_fire ? 1'b1 : (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff.req_type  <= req_tuser;
         item_ff.virt_addr <= req_tdata[ptw_pkg::ADDR_W-1:0];
         item_ff.read_word <= req_tdata[2*ptw_pkg::ADDR_W-1:ptw_pkg::ADDR_W];
      end
   end

   ptw_walk u_walk (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .fire      (walk_fire),
      .item      (item_ff),
      .res_valid (res_valid),
      .res       (res),
      .phase     (phase)
   );

   ptw_out_reg u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (res_valid),
      .res        (res),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .held       (out_res),
      .free       (out_free)
   );

   assign rsp_tuser = out_res.out_kind;
   assign rsp_tdata = {7'd0, out_res.ok, out_res.xlat_addr, out_res.mem_addr};

   // a read request leaves the walker busy, a final result leaves it idle
   a_read_req_busy: assert property (@(posedge clock) disable iff (reset)
      res_valid && (res.out_kind == ptw_pkg::OUT_MEM_READ)
      |=> (phase == ptw_pkg::PH_DIR) || (phase == ptw_pkg::PH_TBL))
      else $error("walker idle after issuing an entry read");

   a_result_idle: assert property (@(posedge clock) disable iff (reset)
      res_valid && (res.out_kind == ptw_pkg::OUT_RESULT) |=> (phase == ptw_pkg::PH_IDLE))
      else $error("walker busy after a translation result");

   // read request beats carry no translation
   a_read_req_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ptw_pkg::OUT_MEM_READ)
      |-> !out_res.ok && (out_res.xlat_addr == '0))
      else $error("read request beat carries a translation");

   // the walk logic only fires when the result register has room
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> (!rsp_tvalid || rsp_tready))
      else $error("result register overwritten while stalled");

endmodule

`default_nettype wire

@@ verif/two_level_page_walker_core_test.sv @@
// self-checking stream testbench for the two-level page walker core
`timescale 1ns / 100ps

module two_level_page_walker_core_test;

   // dropped beats still pass through the input register before vanishing
   localparam int DRAIN_CYCLES = 8;
   localparam int N_PHASES = 8;
   localparam int RESULTS_PER_PHASE = 125;

   localparam logic [ptw_pkg::ADDR_W-1:0] PAGE_MASK  = 32'h0000_0FFF;
   localparam logic [ptw_pkg::ADDR_W-1:0] INDEX_MASK = 32'h0000_03FF;

   localparam ptw_pkg::result_type WALK_FAIL = '{ptw_pkg::OUT_RESULT, 32'h0, 32'h0, 1'b0};

   // one row of the directed table: a register write or a request beat
   typedef struct {
      bit                             is_csr;
      ptw_pkg::item_type              beat;
      logic [ptw_pkg::CSR_IDX_W-1:0]  idx;
      logic [ptw_pkg::CSR_DATA_W-1:0] val;
      bit                             typed;    // expectation written into the row
      bit                             has_rsp;
      ptw_pkg::result_type            want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [ptw_pkg::REQ_DATA_W-1:0] req_tdata  = '0;  // virt_addr, read_word
   logic                           req_tuser  = 1'b0; // req_type
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [ptw_pkg::RSP_DATA_W-1:0] rsp_tdata;        // mem_addr, xlat_addr, ok
   logic                           rsp_tuser;        // out_kind
   logic                           csr_wr_en  = 1'b0;
   logic [ptw_pkg::CSR_IDX_W-1:0]  csr_index  = '0;
   logic [ptw_pkg::CSR_DATA_W-1:0] csr_wdata  = '0;

   // shadow of the walker: registers, phase and the address being walked
   ptw_pkg::cfg_type           csr_shadow;
   ptw_pkg::phase_type         walk_ph;
   logic [ptw_pkg::ADDR_W-1:0] walk_va;

   ptw_pkg::result_type pending_rsp[$];   // predicted response beats, oldest first
   stim_row_type        dir_rows[$];
   int                  mismatches = 0;
   int                  gap_pct    = 0;   // sender idle chance per cycle
   int                  stall_pct  = 0;   // receiver stall chance per cycle

   two_level_page_walker_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // next walker output for one accepted beat; returns 0 when the beat is dropped
   function automatic bit predict_walk(input ptw_pkg::item_type b,
                                       output ptw_pkg::result_type r);
      logic busy;
      busy = (walk_ph == ptw_pkg::PH_DIR) || (walk_ph == ptw_pkg::PH_TBL);
      r = '0;
      if (b.req_type == ptw_pkg::REQ_TRANSLATE) begin
         // a new translation only starts from idle
         if (busy) return 1'b0;
         if (csr_shadow.direct_map_on && b.virt_addr < csr_shadow.kernel_limit) begin
            r.out_kind  = ptw_pkg::OUT_RESULT;
            r.xlat_addr = b.virt_addr;
            r.ok        = 1'b1;
            return 1'b1;
         end
         if (!csr_shadow.paging_on) begin
            r.out_kind = ptw_pkg::OUT_RESULT;
            return 1'b1;
         end
         walk_va    = b.virt_addr;
         walk_ph    = ptw_pkg::PH_DIR;
         r.out_kind = ptw_pkg::OUT_MEM_READ;
         // base need not be aligned, and the 32-bit sum may wrap
         r.mem_addr = csr_shadow.dir_base + ((b.virt_addr >> ptw_pkg::DIR_SHIFT) << 2);
         return 1'b1;
      end
      // stray read data with no walk in flight
      if (!busy) return 1'b0;
      if (!b.read_word[ptw_pkg::PRESENT_BIT] ||
          (csr_shadow.poison_check_on && b.read_word == csr_shadow.poison_word)) begin
         walk_ph    = ptw_pkg::PH_IDLE;
         r.out_kind = ptw_pkg::OUT_RESULT;
         return 1'b1;
      end
      if (walk_ph == ptw_pkg::PH_DIR) begin
         walk_ph    = ptw_pkg::PH_TBL;
         r.out_kind = ptw_pkg::OUT_MEM_READ;
         r.mem_addr = (b.read_word & ~PAGE_MASK) +
                      (((walk_va >> ptw_pkg::TBL_SHIFT) & INDEX_MASK) << 2);
         return 1'b1;
      end
      walk_ph     = ptw_pkg::PH_IDLE;
      r.out_kind  = ptw_pkg::OUT_RESULT;
      r.xlat_addr = (b.read_word & ~PAGE_MASK) + (walk_va & PAGE_MASK);
      r.ok        = 1'b1;
      return 1'b1;
   endfunction

   function automatic void add_beat(input logic kind, input logic [ptw_pkg::ADDR_W-1:0] va,
                                    input logic [ptw_pkg::ADDR_W-1:0] word);
      stim_row_type row;
      row = '{default: '0};
      row.beat = '{kind, va, word};
      dir_rows.push_back(row);
   endfunction

   function automatic void add_typed(input logic kind, input logic [ptw_pkg::ADDR_W-1:0] va,
                                     input logic [ptw_pkg::ADDR_W-1:0] word, input bit has,
                                     input ptw_pkg::result_type want);
      stim_row_type row;
      row = '{default: '0};
      row.beat    = '{kind, va, word};
      row.typed   = 1'b1;
      row.has_rsp = has;
      row.want    = want;
      dir_rows.push_back(row);
   endfunction

   function automatic void add_csr(input logic [ptw_pkg::CSR_IDX_W-1:0] idx,
                                   input logic [ptw_pkg::CSR_DATA_W-1:0] val);
      stim_row_type row;
      row = '{default: '0};
      row.is_csr = 1'b1;
      row.idx    = idx;
      row.val    = val;
      dir_rows.push_back(row);
   endfunction

   // one register write; the caller drops the enable after the last one
   task automatic write_csr(input logic [ptw_pkg::CSR_IDX_W-1:0] idx,
                            input logic [ptw_pkg::CSR_DATA_W-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         ptw_pkg::CSR_DIR_BASE:      csr_shadow.dir_base        = val;
         ptw_pkg::CSR_PAGING_ON:     csr_shadow.paging_on       = val[0];
         ptw_pkg::CSR_DIRECT_MAP_ON: csr_shadow.direct_map_on   = val[0];
         ptw_pkg::CSR_KERNEL_LIMIT:  csr_shadow.kernel_limit    = val;
         ptw_pkg::CSR_POISON_CHK_ON: csr_shadow.poison_check_on = val[0];
         ptw_pkg::CSR_POISON_WORD:   csr_shadow.poison_word     = val;
         default: ;
      endcase
   endtask

   // stop sending, let every predicted beat arrive, then let dropped beats drain
   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_rsp.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // present one request beat, hold it until taken, then predict its outcome
   task automatic send_beat(input ptw_pkg::item_type b, output bit has,
                            output ptw_pkg::result_type r);
      if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < gap_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {b.read_word, b.virt_addr};
      req_tuser  <= b.req_type;
      do @(posedge clock); while (!req_tready);
      has = predict_walk(b, r);
   endtask

   task automatic check_beat();
      ptw_pkg::result_type got, want;
      got.out_kind  = rsp_tuser;
      got.mem_addr  = rsp_tdata[ptw_pkg::ADDR_W-1:0];
      got.xlat_addr = rsp_tdata[2*ptw_pkg::ADDR_W-1:ptw_pkg::ADDR_W];
      got.ok        = rsp_tdata[2*ptw_pkg::ADDR_W];
      if (pending_rsp.size() == 0) begin
         $error("unexpected beat: out_kind %0d mem_addr %h xlat_addr %h ok %0d",
                got.out_kind, got.mem_addr, got.xlat_addr, got.ok);
         mismatches++;
         return;
      end
      want = pending_rsp.pop_front();
      if (got.out_kind !== want.out_kind) begin
         $error("out_kind: expected %0d, actual %0d", want.out_kind, got.out_kind);
         mismatches++;
      end
      if (got.mem_addr !== want.mem_addr) begin
         $error("mem_addr: expected %h, actual %h", want.mem_addr, got.mem_addr);
         mismatches++;
      end
      if (got.xlat_addr !== want.xlat_addr) begin
         $error("xlat_addr: expected %h, actual %h", want.xlat_addr, got.xlat_addr);
         mismatches++;
      end
      if (got.ok !== want.ok) begin
         $error("ok: expected %0d, actual %0d", want.ok, got.ok);
         mismatches++;
      end
   endtask

   // receiver: take beats, check them, stall at random by the current rate
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_beat();
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   initial begin
      ptw_pkg::item_type   b;
      bit                  has;
      ptw_pkg::result_type r;
      int                  pick;
      int                  got_count;

      csr_shadow = '{ptw_pkg::RST_DIR_BASE, 1'b0, 1'b1, ptw_pkg::RST_KERNEL_LIMIT, 1'b0,
                     ptw_pkg::RST_POISON_WORD};
      walk_ph    = ptw_pkg::PH_IDLE;
      walk_va    = '0;

      // --- directed table ---
      // reset defaults: identity map below 16 MiB, paging off
      add_typed(ptw_pkg::REQ_TRANSLATE, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1,
                '{ptw_pkg::OUT_RESULT, 32'h0, 32'h0000_0000, 1'b1});
      add_typed(ptw_pkg::REQ_TRANSLATE, 32'h00FF_FFFF, 32'h0, 1'b1,
                '{ptw_pkg::OUT_RESULT, 32'h0, 32'h00FF_FFFF, 1'b1});
      add_typed(ptw_pkg::REQ_TRANSLATE, 32'h0100_0000, 32'h0, 1'b1, WALK_FAIL);
      add_typed(ptw_pkg::REQ_TRANSLATE, 32'hFFFF_FFFF, 32'h0, 1'b1, WALK_FAIL);
      // read data with nothing in flight is dropped
      add_typed(ptw_pkg::REQ_READ_RSP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, WALK_FAIL);
      add_csr(ptw_pkg::CSR_PAGING_ON, 32'h1);
      // base near the top so the directory address wraps
      add_csr(ptw_pkg::CSR_DIR_BASE, 32'hFFFF_FFFC);
      add_beat(ptw_pkg::REQ_TRANSLATE, 32'hFFFF_FFFF, 32'h0);
      add_beat(ptw_pkg::REQ_TRANSLATE, 32'h0100_0000, 32'h0);    // dropped, walk busy
      add_beat(ptw_pkg::REQ_READ_RSP, 32'h0, 32'hFFFF_FFFF);
      add_beat(ptw_pkg::REQ_READ_RSP, 32'h0, 32'hFFFF_F001);
      add_beat(ptw_pkg::REQ_TRANSLATE, 32'h0200_0000, 32'h0);
      add_typed(ptw_pkg::REQ_READ_RSP, 32'h0, 32'hFFFF_FFFE, 1'b1, WALK_FAIL);  // not present
      add_csr(ptw_pkg::CSR_POISON_CHK_ON, 32'h1);
      add_csr(ptw_pkg::CSR_POISON_WORD, 32'h0000_3001);
      // poison hit on the directory entry, then on the table entry
      add_beat(ptw_pkg::REQ_TRANSLATE, 32'h0300_5ABC, 32'h0);
      add_typed(ptw_pkg::REQ_READ_RSP, 32'h0, 32'h0000_3001, 1'b1, WALK_FAIL);
      add_beat(ptw_pkg::REQ_TRANSLATE, 32'h0300_5ABC, 32'h0);
      add_beat(ptw_pkg::REQ_READ_RSP, 32'h0, 32'h0000_3003);
      add_typed(ptw_pkg::REQ_READ_RSP, 32'h0, 32'h0000_3001, 1'b1, WALK_FAIL);
      add_csr(ptw_pkg::CSR_DIRECT_MAP_ON, 32'h0);
      add_beat(ptw_pkg::REQ_TRANSLATE, 32'h0000_0000, 32'h0);
      add_beat(ptw_pkg::REQ_READ_RSP, 32'h0, 32'h0000_0001);
      add_beat(ptw_pkg::REQ_READ_RSP, 32'h0, 32'h0000_0001);
      // widest kernel region: everything but the top address maps through
      add_csr(ptw_pkg::CSR_KERNEL_LIMIT, 32'hFFFF_FFFF);
      add_csr(ptw_pkg::CSR_DIRECT_MAP_ON, 32'h1);
      add_typed(ptw_pkg::REQ_TRANSLATE, 32'hFFFF_FFFE, 32'h0, 1'b1,
                '{ptw_pkg::OUT_RESULT, 32'h0, 32'hFFFF_FFFE, 1'b1});
      add_beat(ptw_pkg::REQ_TRANSLATE, 32'hFFFF_FFFF, 32'h0);
      add_beat(ptw_pkg::REQ_READ_RSP, 32'h0, 32'h0000_0000);
      add_csr(ptw_pkg::CSR_KERNEL_LIMIT, 32'h0);
      add_beat(ptw_pkg::REQ_TRANSLATE, 32'h0000_0000, 32'h0);
      add_beat(ptw_pkg::REQ_TRANSLATE, 32'h0000_0005, 32'h0);    // dropped, walk busy
      add_beat(ptw_pkg::REQ_READ_RSP, 32'h0, 32'hFFFF_FFFF);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         if (dir_rows[i].is_csr) begin
            settle();
            write_csr(dir_rows[i].idx, dir_rows[i].val);
            csr_wr_en <= 1'b0;
         end else begin
            send_beat(dir_rows[i].beat, has, r);
            if (dir_rows[i].typed) begin
               if (dir_rows[i].has_rsp) pending_rsp.push_back(dir_rows[i].want);
            end else if (has) begin
               pending_rsp.push_back(r);
            end
         end
      end

      // --- random phases: new register set and idle pattern each time ---
      for (int p = 0; p < N_PHASES; p++) begin
         settle();
         case (p % 4)
            0: begin gap_pct = 0;  stall_pct <= 0;  end
            1: begin gap_pct = 79; stall_pct <= 0;  end
            2: begin gap_pct = 0;  stall_pct <= 79; end
            default: begin gap_pct = 20; stall_pct <= 20; end
         endcase
         write_csr(ptw_pkg::CSR_DIR_BASE,
                   (p == 1) ? 32'hFFFF_FFFF : (p == 2) ? 32'h0 : $urandom);
         write_csr(ptw_pkg::CSR_PAGING_ON, (p == 3) ? 32'h0 : 32'h1);
         write_csr(ptw_pkg::CSR_DIRECT_MAP_ON,
                   (p == 4) ? 32'h1 : (p == 0) ? 32'h0 : $urandom_range(1, 0));
         write_csr(ptw_pkg::CSR_KERNEL_LIMIT,
                   (p == 0) ? 32'h0 : (p == 4) ? 32'hFFFF_FFFF :
                   (p == 5) ? ptw_pkg::RST_KERNEL_LIMIT : $urandom);
         write_csr(ptw_pkg::CSR_POISON_CHK_ON,
                   (p == 2 || p == 5 || p == 7) ? 32'h1 : $urandom_range(1, 0));
         write_csr(ptw_pkg::CSR_POISON_WORD,
                   (p == 6) ? 32'h0 : (p == 7) ? 32'hFFFF_FFFF : ($urandom | 32'h1));
         csr_wr_en <= 1'b0;

         got_count = 0;
         while (got_count < RESULTS_PER_PHASE) begin
            b.virt_addr = $urandom;
            b.read_word = $urandom;
            pick = $urandom_range(99);
            if (walk_ph == ptw_pkg::PH_IDLE) begin
               if (pick < 10) begin
                  b.req_type = ptw_pkg::REQ_READ_RSP;    // stray read data, dropped
               end else begin
                  b.req_type = ptw_pkg::REQ_TRANSLATE;
                  if (pick < 15)
                     b.virt_addr = {ptw_pkg::ADDR_W{pick[0]}};
                  else if (pick < 45 && csr_shadow.direct_map_on &&
                           csr_shadow.kernel_limit != 0)
                     b.virt_addr = $urandom_range(csr_shadow.kernel_limit - 1, 0);
               end
            end else begin
               if (pick < 10) begin
                  b.req_type = ptw_pkg::REQ_TRANSLATE;   // walk busy, dropped
               end else begin
                  // mostly good entries so walks reach the table level
                  b.req_type = ptw_pkg::REQ_READ_RSP;
                  if (pick < 20)
                     b.read_word[ptw_pkg::PRESENT_BIT] = 1'b0;
                  else if (pick < 30)
                     b.read_word = csr_shadow.poison_word;
                  else
                     b.read_word[ptw_pkg::PRESENT_BIT] = 1'b1;
               end
            end
            send_beat(b, has, r);
            if (has) begin
               pending_rsp.push_back(r);
               got_count++;
            end
         end
      end

      settle();
      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // watchdog: far beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
